FILE: hdl/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg
// shared codes and controller/datapath command and status types for the
// dual stack shared store unit
// ----------------------------------------------------------------------------
package dss_pkg;

    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_POP  = 2'd1;
    localparam logic [1:0] ACT_DUMP = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;

    typedef struct packed {
        logic push;       // write word, bump count, ok result
        logic overflow;   // overflow result
        logic empty;      // empty result
        logic rd_start;   // latch stack, point at top, first read
        logic is_pop;     // rd_start removes the top word
        logic word_out;   // load result from read data
        logic rd_next;    // step pointer, next read
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic last_word;
    } t_sts;

endpackage

FILE: hdl/dss_req_if.sv
// ----------------------------------------------------------------------------
// dss_req_if
// request channel: valid/ready handshake with action, stack select and word
// ----------------------------------------------------------------------------
interface dss_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic               which_stack;
    logic signed [31:0] value;

    modport source (output valid, action, which_stack, value, input ready);
    modport sink   (input valid, action, which_stack, value, output ready);
endinterface

FILE: hdl/dss_rsp_if.sv
// ----------------------------------------------------------------------------
// dss_rsp_if
// result channel: valid/ready handshake with status, word and last marker
// ----------------------------------------------------------------------------
interface dss_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] data;
    logic               last;

    modport source (output valid, status, data, last, input ready);
    modport sink   (input valid, status, data, last, output ready);
endinterface

FILE: hdl/dss_ctrl.sv
// ----------------------------------------------------------------------------
// dss_ctrl
// controller: decodes requests, sequences pop and dump reads, owns the
// result valid flag
// ----------------------------------------------------------------------------
module dss_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  logic [1:0]    i_action,
    output logic          o_req_ready,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output dss_pkg::t_cmd o_cmd,
    input  dss_pkg::t_sts i_sts
);
    import dss_pkg::*;

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_STREAM = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic slot_free;
    logic accept;
    logic load;

    assign slot_free   = !r_out_valid || i_rsp_ready;
    assign o_req_ready = (r_state == S_IDLE) && slot_free;
    assign accept      = o_req_ready && i_req_valid;
    assign o_rsp_valid = r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_action)
                        ACT_PUSH: begin
                            if (i_sts.full) begin
                                o_cmd.overflow = 1'b1;
                            end else begin
                                o_cmd.push = 1'b1;
                            end
                        end
                        ACT_POP, ACT_DUMP: begin
                            if (i_sts.empty) begin
                                o_cmd.empty = 1'b1;
                            end else begin
                                o_cmd.rd_start = 1'b1;
                                o_cmd.is_pop   = (i_action == ACT_POP);
                                n_state        = S_STREAM;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_STREAM: begin
                if (slot_free) begin
                    o_cmd.word_out = 1'b1;
                    if (i_sts.last_word) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rd_next = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign load = o_cmd.push || o_cmd.overflow || o_cmd.empty || o_cmd.word_out;

    always_comb begin
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: hdl/dss_dpath.sv
// ----------------------------------------------------------------------------
// dss_dpath
// datapath: shared word store, both stack counts, read pointer and the
// result register
// ----------------------------------------------------------------------------
module dss_dpath #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dss_pkg::t_cmd      i_cmd,
    output dss_pkg::t_sts      o_sts,
    input  logic               i_which,
    input  logic signed [31:0] i_value,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_data,
    output logic               o_last
);
    import dss_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [AW-1:0] STEP_C  = AW'(1);

    logic [31:0]   mem [DEPTH];
    logic [31:0]   r_rdata;

    logic [CW-1:0] r_lower, n_lower;
    logic [CW-1:0] r_upper, n_upper;
    logic [CW-1:0] r_remain, n_remain;
    logic [AW-1:0] r_ptr, n_ptr;
    logic          r_sel;

    logic [1:0]    r_status;
    logic [31:0]   r_data;
    logic          r_last;

    logic [CW-1:0] sel_cnt;
    logic [CW:0]   used;
    logic [AW-1:0] push_addr;
    logic [AW-1:0] top_addr;
    logic [AW-1:0] next_ptr;
    logic [AW-1:0] rd_addr;
    logic          rd_en;

    assign sel_cnt = i_which ? r_upper : r_lower;
    assign used    = {1'b0, r_lower} + {1'b0, r_upper};

    assign o_sts.full      = used >= {1'b0, DEPTH_C};
    assign o_sts.empty     = (sel_cnt == '0);
    assign o_sts.last_word = (r_remain == ONE_C);

    assign push_addr = i_which ? AW'(DEPTH_C - r_upper - ONE_C) : AW'(r_lower);
    assign top_addr  = i_which ? AW'(DEPTH_C - r_upper) : AW'(r_lower - ONE_C);
    assign next_ptr  = r_sel ? (r_ptr + STEP_C) : (r_ptr - STEP_C);
    assign rd_addr   = i_cmd.rd_start ? top_addr : next_ptr;
    assign rd_en     = i_cmd.rd_start || i_cmd.rd_next;

    always_comb begin
        n_lower  = r_lower;
        n_upper  = r_upper;
        n_remain = r_remain;
        n_ptr    = r_ptr;
        if (i_cmd.push) begin
            if (i_which) begin
                n_upper = r_upper + ONE_C;
            end else begin
                n_lower = r_lower + ONE_C;
            end
        end
        if (i_cmd.rd_start) begin
            n_ptr    = top_addr;
            n_remain = i_cmd.is_pop ? ONE_C : sel_cnt;
            if (i_cmd.is_pop) begin
                if (i_which) begin
                    n_upper = r_upper - ONE_C;
                end else begin
                    n_lower = r_lower - ONE_C;
                end
            end
        end
        if (i_cmd.rd_next) begin
            n_ptr    = next_ptr;
            n_remain = r_remain - ONE_C;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower  <= '0;
            r_upper  <= '0;
            r_remain <= '0;
            r_ptr    <= '0;
            r_sel    <= 1'b0;
        end else begin
            r_lower  <= n_lower;
            r_upper  <= n_upper;
            r_remain <= n_remain;
            r_ptr    <= n_ptr;
            if (i_cmd.rd_start) begin
                r_sel <= i_which;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[push_addr] <= i_value;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_status <= ST_OK;
            r_data   <= '0;
            r_last   <= 1'b1;
        end else if (i_cmd.overflow) begin
            r_status <= ST_OVERFLOW;
            r_data   <= '0;
            r_last   <= 1'b1;
        end else if (i_cmd.empty) begin
            r_status <= ST_EMPTY;
            r_data   <= '0;
            r_last   <= 1'b1;
        end else if (i_cmd.word_out) begin
            r_status <= ST_OK;
            r_data   <= r_rdata;
            r_last   <= o_sts.last_word;
        end
    end

    assign o_status = r_status;
    assign o_data   = r_data;
    assign o_last   = r_last;

endmodule

FILE: hdl/dual_stack_shared_store_unit.sv
// ----------------------------------------------------------------------------
// dual_stack_shared_store_unit
// two stacks in one store: lower grows up, upper grows down
// ----------------------------------------------------------------------------
// channel  dir  fields                         handshake
// i_req    in   action, which_stack, value     valid/ready
// o_rsp    out  status, data, last             valid/ready
//
// push, refused push and empty results: result on the next cycle
// pop: the store port read is registered, then the word goes to the result register
// dump: a first read of the top word, then one word per cycle while o_rsp is taken
// reset clears both counts and the result flag; the store is not cleared
// a stalled result holds; a new request is taken once idle and the result slot frees
// ----------------------------------------------------------------------------
module dual_stack_shared_store_unit #(
    parameter int DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dss_req_if.sink    i_req,
    dss_rsp_if.source  o_rsp
);
    import dss_pkg::*;

    t_cmd cmd;
    t_sts sts;

    dss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_action    (i_req.action),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    dss_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .i_which  (i_req.which_stack),
        .i_value  (i_req.value),
        .o_status (o_rsp.status),
        .o_data   (o_rsp.data),
        .o_last   (o_rsp.last)
    );

endmodule

FILE: hdl/dss_checker.sv
// ----------------------------------------------------------------------------
// dss_checker
// port level checks on the dual stack shared store unit
// ----------------------------------------------------------------------------
module dss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic [1:0]  i_req_action,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [1:0]  i_rsp_status,
    input logic [31:0] i_rsp_data,
    input logic        i_rsp_last
);
    import dss_pkg::*;

    // stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_data)
            && $stable(i_rsp_last))
        else $error("stalled result changed");

    // error results close the request and carry no word
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != ST_OK |-> i_rsp_last && i_rsp_data == '0)
        else $error("error result not final or carries data");

    // a taken push answers on the next cycle with ok or overflow
    a_push_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && i_req_action == ACT_PUSH |=>
            i_rsp_valid && i_rsp_last && i_rsp_status != ST_EMPTY)
        else $error("push result missing or wrong");

    // overflow only answers a push
    a_ovf_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && i_req_action != ACT_PUSH |=>
            !(i_rsp_valid && $changed(i_rsp_valid) && i_rsp_status == ST_OVERFLOW))
        else $error("overflow for a non-push request");

endmodule

bind dual_stack_shared_store_unit dss_checker u_dss_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_req_action (i_req.action),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_data   (o_rsp.data),
    .i_rsp_last   (o_rsp.last)
);

FILE: tb/dss_result_board_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dss_result_board_pkg
// scoreboard for the dual stack shared store unit: keeps its own copy of the
// two stacks, works out the results each accepted request causes, and checks
// each result taken from the block against the oldest one awaited
// ----------------------------------------------------------------------------
package dss_result_board_pkg;

    import dss_pkg::*;

    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam logic       STACK_LOWER = 1'b0;
    localparam logic       STACK_UPPER = 1'b1;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] data;
        logic        last;
    } stack_result_t;

    class stack_result_board #(parameter int DEPTH = 16);

        logic [31:0]   store_words [DEPTH];
        int unsigned   lower_fill;
        int unsigned   upper_fill;
        stack_result_t awaited [$];
        int unsigned   mismatch_count;

        function new();
            lower_fill     = 0;
            upper_fill     = 0;
            mismatch_count = 0;
        endfunction

        function void await_result(logic [1:0] status, logic [31:0] data, logic last);
            awaited.push_back(stack_result_t'{status, data, last});
        endfunction

        function void note_request(logic [1:0] act, logic stk, logic [31:0] val);
            int unsigned fill;
            int unsigned idx;
            fill = (stk == STACK_UPPER) ? upper_fill : lower_fill;
            case (act)
                ACT_PUSH: begin
                    if (lower_fill + upper_fill >= DEPTH) begin
                        await_result(ST_OVERFLOW, '0, 1'b1);
                    end else if (stk == STACK_UPPER) begin
                        upper_fill++;
                        store_words[DEPTH - upper_fill] = val;
                        await_result(ST_OK, '0, 1'b1);
                    end else begin
                        store_words[lower_fill] = val;
                        lower_fill++;
                        await_result(ST_OK, '0, 1'b1);
                    end
                end
                ACT_POP: begin
                    if (fill == 0) begin
                        await_result(ST_EMPTY, '0, 1'b1);
                    end else if (stk == STACK_UPPER) begin
                        await_result(ST_OK, store_words[DEPTH - upper_fill], 1'b1);
                        upper_fill--;
                    end else begin
                        lower_fill--;
                        await_result(ST_OK, store_words[lower_fill], 1'b1);
                    end
                end
                ACT_DUMP: begin
                    if (fill == 0) begin
                        await_result(ST_EMPTY, '0, 1'b1);
                    end else begin
                        for (int unsigned i = 0; i < fill; i++) begin
                            idx = (stk == STACK_UPPER) ? (DEPTH - upper_fill + i)
                                                       : (lower_fill - 1 - i);
                            await_result(ST_OK, store_words[idx], (i + 1 == fill));
                        end
                    end
                end
                default: begin
                end
            endcase
        endfunction

        task report_mismatch(string what);
            mismatch_count++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(logic [1:0] status, logic [31:0] data, logic last);
            stack_result_t want;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("result with none awaited: status %0d data %h last %b",
                                          status, data, last));
                return;
            end
            want = awaited.pop_front();
            if (status !== want.status) begin
                report_mismatch($sformatf("status %0d, wanted %0d", status, want.status));
            end
            if (data !== want.data) begin
                report_mismatch($sformatf("data %h, wanted %h", data, want.data));
            end
            if (last !== want.last) begin
                report_mismatch($sformatf("last %b, wanted %b", last, want.last));
            end
        endtask

    endclass

endpackage

FILE: tb/dual_stack_shared_store_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_stack_shared_store_unit_tb
// drives push, pop, dump and unused requests into both stacks, first a short
// directed run over empty stacks and extreme words, then random stretches that
// fill towards overflow and drain towards empty, under changing idle patterns
// on both channels and one long result hold-off; every result is checked
// against the scoreboard's own copy of the stacks
// ----------------------------------------------------------------------------
module dual_stack_shared_store_unit_tb;

    import dss_pkg::*;
    import dss_result_board_pkg::*;

    localparam int DEPTH         = 16;
    localparam int RESET_CYCLES  = 11;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int QUIET_LIMIT   = 2000;

    logic i_clk;
    logic i_rst_n;

    dss_req_if i_req_if ();
    dss_rsp_if o_rsp_if ();

    stack_result_board #(.DEPTH(DEPTH)) board;

    int unsigned send_idle_pct = 0;
    int unsigned rcv_idle_pct  = 0;
    int unsigned quiet_cycles  = 0;
    logic        hold_request  = 1'b0;

    dual_stack_shared_store_unit #(.DEPTH(DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req_if),
        .o_rsp   (o_rsp_if)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    task automatic send_request(input logic [1:0] act, input logic stk,
                                input logic [31:0] val);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_if.valid       <= 1'b1;
        i_req_if.action      <= act;
        i_req_if.which_stack <= stk;
        i_req_if.value       <= val;
        do @(posedge i_clk); while (i_req_if.ready !== 1'b1);
    endtask

    task automatic wait_drained();
        i_req_if.valid <= 1'b0;
        do @(posedge i_clk); while (board.awaited.size() != 0);
    endtask

    // stretches lean towards filling or draining, and sometimes towards one stack
    task automatic send_random(input int unsigned n_items);
        int unsigned sent;
        int unsigned stretch;
        int unsigned lean;
        int unsigned roll;
        logic        filling;
        logic [1:0]  act;
        logic        stk;
        logic [31:0] word;
        sent    = 0;
        stretch = 0;
        lean    = 0;
        filling = 1'b0;
        while (sent < n_items) begin
            if (stretch == 0) begin
                stretch = $urandom_range(15, 45);
                filling = ~filling;
                lean    = $urandom_range(0, 2);
            end
            stretch--;
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                act = ACT_UNUSED;
            end else if (roll < 15) begin
                act = ACT_DUMP;
            end else if (roll < (filling ? 85 : 35)) begin
                act = ACT_PUSH;
            end else begin
                act = ACT_POP;
            end
            case (lean)
                1: begin
                    stk = ($urandom_range(0, 9) == 0) ? STACK_UPPER : STACK_LOWER;
                end
                2: begin
                    stk = ($urandom_range(0, 9) == 0) ? STACK_LOWER : STACK_UPPER;
                end
                default: begin
                    stk = 1'($urandom_range(0, 1));
                end
            endcase
            case ($urandom_range(0, 9))
                0: word = 32'h8000_0000;
                1: word = 32'h7fff_ffff;
                2: word = 32'h0000_0000;
                3: word = 32'hffff_ffff;
                default: word = $urandom();
            endcase
            send_request(act, stk, word);
            if (act != ACT_UNUSED) begin
                sent++;
            end
        end
    endtask

    initial begin : request_driver
        board                = new();
        i_rst_n              = 1'b0;
        i_req_if.valid       = 1'b0;
        i_req_if.action      = ACT_PUSH;
        i_req_if.which_stack = STACK_LOWER;
        i_req_if.value       = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(ACT_POP,    STACK_LOWER, 32'h0000_0000);
        send_request(ACT_POP,    STACK_UPPER, 32'hffff_ffff);
        send_request(ACT_DUMP,   STACK_LOWER, 32'h0000_0000);
        send_request(ACT_DUMP,   STACK_UPPER, 32'h0000_0000);
        send_request(ACT_UNUSED, STACK_LOWER, 32'h1234_5678);
        send_request(ACT_UNUSED, STACK_UPPER, 32'hffff_ffff);
        send_request(ACT_PUSH,   STACK_LOWER, 32'h8000_0000);
        send_request(ACT_PUSH,   STACK_LOWER, 32'h7fff_ffff);
        send_request(ACT_PUSH,   STACK_UPPER, 32'h0000_0000);
        send_request(ACT_PUSH,   STACK_UPPER, 32'hffff_ffff);
        send_request(ACT_PUSH,   STACK_UPPER, 32'h5a5a_a5a5);
        send_request(ACT_DUMP,   STACK_LOWER, 32'h0000_0000);
        send_request(ACT_DUMP,   STACK_UPPER, 32'h0000_0000);
        send_request(ACT_UNUSED, STACK_LOWER, 32'h0000_0000);
        send_request(ACT_POP,    STACK_UPPER, 32'h0000_0000);
        send_request(ACT_POP,    STACK_LOWER, 32'h0000_0000);
        send_request(ACT_DUMP,   STACK_LOWER, 32'h0000_0000);
        send_request(ACT_POP,    STACK_LOWER, 32'h0000_0000);
        send_request(ACT_POP,    STACK_LOWER, 32'h0000_0000);
        send_request(ACT_DUMP,   STACK_UPPER, 32'h0000_0000);
        send_request(ACT_POP,    STACK_UPPER, 32'h0000_0000);
        send_request(ACT_POP,    STACK_UPPER, 32'h0000_0000);
        send_request(ACT_POP,    STACK_UPPER, 32'h0000_0000);
        wait_drained();

        send_idle_pct = 29;
        rcv_idle_pct  = 49;
        send_random(140);
        wait_drained();

        send_idle_pct = 49;
        rcv_idle_pct  = 29;
        send_random(140);

        // result side held off while requests keep coming
        send_idle_pct = 0;
        hold_request  = 1'b1;
        send_random(30);
        wait_drained();

        send_idle_pct = 0;
        rcv_idle_pct  = 0;
        send_random(150);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.mismatch_count == 0) begin
            $display("dual_stack_shared_store_unit verification clean");
        end else begin
            $display("dual_stack_shared_store_unit verification failed");
        end
        $finish;
    end

    initial begin : result_taker
        int unsigned hold_left;
        logic        hold_taken;
        hold_left      = 0;
        hold_taken     = 1'b0;
        o_rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_taken) begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left != 0) begin
                hold_left--;
                o_rsp_if.ready <= 1'b0;
            end else begin
                o_rsp_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_req_if.valid && i_req_if.ready) begin
                board.note_request(i_req_if.action, i_req_if.which_stack, i_req_if.value);
            end
            if (o_rsp_if.valid && o_rsp_if.ready) begin
                board.check_result(o_rsp_if.status, o_rsp_if.data, o_rsp_if.last);
            end
            if ((i_req_if.valid && i_req_if.ready) || (o_rsp_if.valid && o_rsp_if.ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin : watchdog
        wait (i_rst_n === 1'b1);
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("[%0t] no request or result moved for %0d cycles", $time, QUIET_LIMIT);
        $display("dual_stack_shared_store_unit verification failed");
        $finish;
    end

endmodule
